### src/ecss_pkg.sv
package ecss_pkg;

  localparam int unsigned FifoDepthDef = 64;
  localparam int unsigned LanesDef     = 2;

  localparam int unsigned LaneW     = 32;
  localparam int unsigned PinLanes  = 2;
  localparam int unsigned SampleW   = LaneW * PinLanes;
  localparam int unsigned UnderrunW = 32;
  localparam int unsigned FillW     = 7;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_CLOCK_MODE  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_LANE_IS_BIT = CfgIdxW'(1);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_FREE_RUN = 2'd0,
    MODE_FALLING  = 2'd1,
    MODE_RISING   = 2'd2,
    MODE_ANY_EDGE = 2'd3
  } mode_e;

endpackage

### src/ecss_if.sv
interface ecss_cfg_if import ecss_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

interface ecss_in_if import ecss_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [SampleW-1:0] sample_word;
  logic               clock_level;
  logic               stream_enable;

  modport source (output valid, output operation, output sample_word,
                  output clock_level, output stream_enable, input ready);
  modport sink   (input valid, input operation, input sample_word,
                  input clock_level, input stream_enable, output ready);
endinterface

interface ecss_out_if import ecss_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 push_accepted;
  logic                 pins_updated;
  logic [SampleW-1:0]   pin_values;
  logic [FillW-1:0]     fill_level;
  logic                 fifo_empty;
  logic [UnderrunW-1:0] underrun_count;

  modport source (output valid, output push_accepted, output pins_updated,
                  output pin_values, output fill_level, output fifo_empty,
                  output underrun_count, input ready);
  modport sink   (input valid, input push_accepted, input pins_updated,
                  input pin_values, input fill_level, input fifo_empty,
                  input underrun_count, output ready);
endinterface

### src/edge_clocked_sample_streamer.sv
// An item is registered into the first stage when it is accepted, and its result into the
// result stage when the first stage advances, which waits while a held result is not taken.
// Throughput: one item per cycle while results are taken; the sample store is read
// through the registered read port of the RAM, which loads beside the first stage.
// Reset: edge history, pointers, fill level, underrun counter, held pins and
// configuration clear at once; sample store contents are undefined until pushed.
module edge_clocked_sample_streamer import ecss_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FifoDepthDef,
  parameter int unsigned LANES      = LanesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ecss_cfg_if.sink      cfg_i,
  ecss_in_if.sink       in_i,
  ecss_out_if.source    out_o
);

  localparam int unsigned PtrW   = $clog2(FIFO_DEPTH);
  localparam int unsigned LevelW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0]   LastIdx   = PtrW'(FIFO_DEPTH - 1);
  localparam logic [LevelW-1:0] FullLevel = LevelW'(FIFO_DEPTH);

  // Configuration.
  mode_e      pop_mode_q;
  logic [1:0] lane_is_bit_q;

  // Control state, updated as each item is accepted.
  logic [1:0]           hist_q, hist_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [LevelW-1:0]    occ_q, occ_d;
  logic [UnderrunW-1:0] underrun_q, underrun_d;

  // First stage.
  logic              s1_valid_q, s1_accept_q, s1_pop_q;
  logic [LevelW-1:0] s1_level_q;
  logic              s1_accept_d, s1_pop_d;

  // Result stage.
  logic                 out_valid_q, out_accept_q, out_pop_q, out_empty_q;
  logic [LevelW-1:0]    out_level_q;
  logic [UnderrunW-1:0] out_underrun_q;
  logic [SampleW-1:0]   held_q, pins_d, loaded;

  logic               in_fire, s1_adv, full, empty, pop_due;
  logic               ram_we, ram_re;
  logic [SampleW-1:0] ram_rdata;
  logic [1:0]         hist_next;
  op_e                op;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_mode_q    <= MODE_FREE_RUN;
      lane_is_bit_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_CLOCK_MODE:  pop_mode_q    <= mode_e'(cfg_i.wdata[1:0]);
        CFG_LANE_IS_BIT: lane_is_bit_q <= cfg_i.wdata[1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;
  assign op         = op_e'(in_i.operation);
  assign full       = (occ_q == FullLevel);
  assign empty      = (occ_q == '0);
  assign hist_next  = {hist_q[0], in_i.clock_level};

  always_comb begin
    pop_due = 1'b0;
    if (in_i.stream_enable) begin
      unique case (pop_mode_q)
        MODE_FREE_RUN: pop_due = 1'b1;
        MODE_FALLING:  pop_due = (hist_next == 2'b10);
        MODE_RISING:   pop_due = (hist_next == 2'b01);
        MODE_ANY_EDGE: pop_due = hist_next[1] ^ hist_next[0];
        default:       pop_due = 1'b0;
      endcase
    end
  end

  always_comb begin
    hist_d      = hist_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    occ_d       = occ_q;
    underrun_d  = underrun_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    s1_accept_d = 1'b0;
    s1_pop_d    = 1'b0;
    if (in_fire) begin
      unique case (op)
        OP_PUSH: begin
          if (!full) begin
            ram_we      = 1'b1;
            wr_ptr_d    = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
            occ_d       = occ_q + LevelW'(1);
            s1_accept_d = 1'b1;
          end
        end
        OP_TICK: begin
          hist_d = hist_next;
          if (pop_due) begin
            if (empty) begin
              underrun_d = underrun_q + UnderrunW'(1);
            end else begin
              ram_re   = 1'b1;
              rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
              occ_d    = occ_q - LevelW'(1);
              s1_pop_d = 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          rd_ptr_d = '0;
          wr_ptr_d = '0;
          occ_d    = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q     <= '0;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      occ_q      <= '0;
      underrun_q <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      hist_q     <= hist_d;
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      occ_q      <= occ_d;
      underrun_q <= underrun_d;
      if (s1_adv || !s1_valid_q) begin
        s1_valid_q <= in_fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_accept_q <= s1_accept_d;
      s1_pop_q    <= s1_pop_d;
      s1_level_q  <= occ_q;
    end
  end

  ecss_ram #(
    .Width (SampleW),
    .Depth (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (in_i.sample_word),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // Lanes past LANES are never loaded and keep their reset value.
  for (genvar l = 0; l < PinLanes; l++) begin : g_lane
    logic [LaneW-1:0] word;
    assign word = ram_rdata[l*LaneW +: LaneW];
    if (l < LANES) begin : g_used
      assign loaded[l*LaneW +: LaneW] =
        lane_is_bit_q[l] ? {{(LaneW-1){1'b0}}, |word} : word;
    end else begin : g_unused
      assign loaded[l*LaneW +: LaneW] = held_q[l*LaneW +: LaneW];
    end
  end

  assign pins_d = s1_pop_q ? loaded : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        held_q      <= pins_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The underrun total cannot move past this item while it waits in stage one.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_accept_q   <= s1_accept_q;
      out_pop_q      <= s1_pop_q;
      out_level_q    <= s1_level_q;
      out_empty_q    <= (s1_level_q == '0);
      out_underrun_q <= underrun_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.push_accepted  = out_accept_q;
  assign out_o.pins_updated   = out_pop_q;
  assign out_o.pin_values     = held_q;
  assign out_o.fill_level     = FillW'(out_level_q);
  assign out_o.fifo_empty     = out_empty_q;
  assign out_o.underrun_count = out_underrun_q;

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= FullLevel)
    else $error("fill level above depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0 || occ_q == FullLevel) |-> (rd_ptr_q == wr_ptr_q))
    else $error("pointers disagree with fill level");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_pop_q) |-> (out_level_q != '0 && !out_accept_q))
    else $error("pop reported from empty fifo or with a push");

  a_underrun_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (underrun_q != $past(underrun_q)) |->
      ($past(in_fire) && underrun_q == $past(underrun_q) + UnderrunW'(1)))
    else $error("underrun counter moved without an item");
`endif

endmodule

### src/ecss_ram.sv
module ecss_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
